>>> src/sckc_pkg.sv
// Shared types, constants and the scancode map for the scancode-to-keycode tracker.
// Depends on nothing; every other file imports it.
package sckc_pkg;

  // Held-key ring size and derived widths
  localparam int HELD_DEPTH = 64;
  localparam int MAX_RUN    = 64;
  localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
  localparam int STEP_W     = CNT_W;
  localparam int SUM_W      = STEP_W + 1;
  localparam int RUN_W      = $clog2(MAX_RUN + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 7;

  // Highest plain scancode that maps to itself
  localparam logic [CODE_W-1:0] PLAIN_TOP = 8'h53;

  // Opcodes
  localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
  localparam logic [OP_W-1:0] OP_DUMP  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Ring shift controls
  typedef struct packed {
    logic fwd;        // every cell takes its upper neighbor
    logic bwd;        // every cell takes its lower neighbor
    logic head_load;  // on fwd, head cell takes head_val instead
    logic tail_load;  // on fwd, tail cell takes tail_val instead
  } ring_ctl_t;

  // Extended (prefixed) scancode to keycode; 0 means no mapping
  function automatic code_t map_extended(input code_t sc);
    code_t r;
    case (sc)
      8'h1C:   r = 8'd96;
      8'h1D:   r = 8'd97;
      8'h35:   r = 8'd98;
      8'h37:   r = 8'd99;
      8'h38:   r = 8'd100;
      8'h47:   r = 8'd102;
      8'h48:   r = 8'd103;
      8'h49:   r = 8'd104;
      8'h4B:   r = 8'd105;
      8'h4D:   r = 8'd106;
      8'h4F:   r = 8'd107;
      8'h50:   r = 8'd108;
      8'h51:   r = 8'd109;
      8'h52:   r = 8'd110;
      8'h53:   r = 8'd111;
      8'h5B:   r = 8'd125;
      8'h5C:   r = 8'd126;
      8'h5D:   r = 8'd127;
      8'h1F:   r = 8'd142;
      8'h20:   r = 8'd113;
      8'h2E:   r = 8'd114;
      8'h30:   r = 8'd115;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Held count as carried in a result (masked to the field width)
  function automatic logic [COUNT_W-1:0] count_field(input cnt_t cnt);
    return COUNT_W'(cnt);
  endfunction

endpackage

>>> src/sckc_evt_if.sv
// Key event input channel: valid/ready handshake with the event payload.
// Depends on sckc_pkg.
interface sckc_evt_if;
  import sckc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CODE_W-1:0] scancode;
  logic              extended;
  logic              key_down;

  modport source (output valid, output opcode, output scancode, output extended,
                  output key_down, input ready);
  modport sink   (input valid, input opcode, input scancode, input extended,
                  input key_down, output ready);
endinterface

>>> src/sckc_res_if.sv
// Result output channel: valid/ready handshake with the result payload.
// Depends on sckc_pkg.
interface sckc_res_if;
  import sckc_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [CODE_W-1:0]  keycode;
  logic [COUNT_W-1:0] held_count;
  logic [CODE_W-1:0]  held_key;
  logic               held_valid;
  logic               last;

  modport source (output valid, output accepted, output keycode, output held_count,
                  output held_key, output held_valid, output last, input ready);
  modport sink   (input valid, input accepted, input keycode, input held_count,
                  input held_key, input held_valid, input last, output ready);
endinterface

>>> src/scancode_to_keycode_with_held_set.sv
// Scancode-to-keycode tracker top level: event decode, ring controller, result register.
// Depends on sckc_pkg, sckc_evt_if, sckc_res_if and sckc_ring.
//
//   channel | dir | payload                                                  | handshake
//   --------+-----+----------------------------------------------------------+----------
//   evt     | in  | opcode, scancode, extended, key_down                     | valid/ready
//   res     | out | accepted, keycode, held_count, held_key, held_valid, last | valid/ready
//
// A key event makes one full turn of the held-key ring past the head cell, one fix-up
// shift, then posts the result. A dump makes one full turn, emitting live entries; clear
// and other opcodes post the result directly. Every item waits longer while the result
// register holds a transaction the result side has not taken.
// One item is in work at a time; evt.ready is high only when idle.
// Synchronous reset empties the held set; ring contents are left as they are.
module scancode_to_keycode_with_held_set (
  input logic      clk,
  input logic      rst,
  sckc_evt_if.sink evt,
  sckc_res_if.source res
);
  import sckc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_FIX   = 5'b00100,
    ST_DUMP  = 5'b01000,
    ST_REPLY = 5'b10000
  } state_t;

  state_t           state, state_next;
  cnt_t             total, total_next;
  logic [STEP_W-1:0] step, step_next;
  logic [RUN_W-1:0] emitted, emitted_next;
  logic [RUN_W-1:0] run_len, run_len_next;
  code_t            code, code_next;
  code_t            last_val, last_val_next;
  logic             down, down_next;
  logic             acc, acc_next;
  logic             found, found_next;

  ring_ctl_t ring_ctl;
  code_t     head_val, tail_val, head;

  logic  out_free, out_load;
  logic  out_acc, out_valid_key, out_last;
  code_t out_code, out_key;

  code_t mapped;
  logic  in_window, hit, dump_take;

  sckc_ring u_ring (
    .clk      (clk),
    .ctl      (ring_ctl),
    .head_val (head_val),
    .tail_val (tail_val),
    .head     (head)
  );

  // Map the incoming scancode
  always_comb begin
    if (evt.extended) begin
      mapped = map_extended(evt.scancode);
    end else if (evt.scancode <= PLAIN_TOP) begin
      mapped = evt.scancode;
    end else begin
      mapped = '0;
    end
  end

  // Head holds a live entry once step + total passes the ring depth
  assign in_window = (SUM_W'(step) + SUM_W'(total)) > SUM_W'(HELD_DEPTH);
  assign hit       = (total != '0) && ((step == '0) || in_window) && (head == code);
  assign dump_take = in_window && (emitted < run_len);
  assign out_free  = !res.valid || res.ready;
  assign evt.ready = (state == ST_IDLE);

  // Sequence the passes over the ring
  always_comb begin
    state_next    = state;
    total_next    = total;
    step_next     = step;
    emitted_next  = emitted;
    run_len_next  = run_len;
    code_next     = code;
    last_val_next = last_val;
    down_next     = down;
    acc_next      = acc;
    found_next    = found;
    ring_ctl      = '0;
    head_val      = code;
    tail_val      = last_val;
    out_load      = 1'b0;
    out_acc       = acc;
    out_code      = code;
    out_key       = '0;
    out_valid_key = 1'b0;
    out_last      = 1'b1;

    case (state)
      ST_IDLE: begin
        if (evt.valid) begin
          acc_next  = 1'b0;
          code_next = '0;
          down_next = evt.key_down;
          case (evt.opcode)
            OP_KEY: begin
              if (mapped != '0) begin
                acc_next   = 1'b1;
                code_next  = mapped;
                found_next = 1'b0;
                step_next  = '0;
                state_next = ST_SCAN;
              end else begin
                state_next = ST_REPLY;
              end
            end
            OP_DUMP: begin
              if (total != '0) begin
                ring_ctl.fwd = 1'b1;
                step_next    = STEP_W'(1);
                emitted_next = '0;
                run_len_next = (total > CNT_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(total);
                state_next   = ST_DUMP;
              end else begin
                state_next = ST_REPLY;
              end
            end
            OP_CLEAR: begin
              total_next = '0;
              state_next = ST_REPLY;
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Rotate one full turn; drop a released key by writing the last entry over it
        ring_ctl.fwd = 1'b1;
        if (step == '0) begin
          last_val_next = head;
          tail_val      = head;
        end
        if (hit) begin
          found_next = 1'b1;
          if (!down) begin
            ring_ctl.tail_load = 1'b1;
          end
        end
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(HELD_DEPTH - 1)) begin
          state_next = ST_FIX;
        end
      end

      ST_FIX: begin
        // Park the head on the new last entry, appending a fresh press
        if (found && !down) begin
          ring_ctl.bwd = 1'b1;
          total_next   = total - CNT_W'(1);
        end else if (!found && down && (total < CNT_W'(HELD_DEPTH))) begin
          ring_ctl.fwd       = 1'b1;
          ring_ctl.head_load = 1'b1;
          total_next         = total + CNT_W'(1);
        end
        state_next = ST_REPLY;
      end

      ST_DUMP: begin
        // Emit live entries in stored order, stalling on a full result register
        out_acc       = 1'b0;
        out_code      = '0;
        out_key       = head;
        out_valid_key = 1'b1;
        out_last      = ((emitted + RUN_W'(1)) == run_len);
        if (!dump_take || out_free) begin
          if (dump_take) begin
            out_load     = 1'b1;
            emitted_next = emitted + RUN_W'(1);
          end
          if (step == STEP_W'(HELD_DEPTH)) begin
            state_next = ST_IDLE;
          end else begin
            ring_ctl.fwd = 1'b1;
            step_next    = step + STEP_W'(1);
          end
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      found <= found_next;
    end
  end

  // Hold working registers
  always_ff @(posedge clk) begin
    step     <= step_next;
    emitted  <= emitted_next;
    run_len  <= run_len_next;
    code     <= code_next;
    last_val <= last_val_next;
    down     <= down_next;
    acc      <= acc_next;
  end

  // Result register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.accepted   <= out_acc;
      res.keycode    <= out_code;
      res.held_count <= count_field(total_next);
      res.held_key   <= out_key;
      res.held_valid <= out_valid_key;
      res.last       <= out_last;
    end
  end

endmodule

>>> src/sckc_cell.sv
// One held-key cell of the ring: stores a keycode, takes a neighbor's value on a shift.
// Depends on sckc_pkg.
module sckc_cell (
  input  logic                clk,
  input  sckc_pkg::ring_ctl_t ctl,
  input  sckc_pkg::code_t     fwd_in,
  input  sckc_pkg::code_t     bwd_in,
  output sckc_pkg::code_t     key
);
  import sckc_pkg::*;

  // Shift forward or backward; hold otherwise
  always_ff @(posedge clk) begin
    if (ctl.fwd) begin
      key <= fwd_in;
    end else if (ctl.bwd) begin
      key <= bwd_in;
    end
  end

endmodule

>>> src/sckc_ring.sv
// Circular chain of held-key cells; cell 0 is the head seen by the controller.
// Depends on sckc_pkg and sckc_cell.
module sckc_ring (
  input  logic                clk,
  input  sckc_pkg::ring_ctl_t ctl,
  input  sckc_pkg::code_t     head_val,
  input  sckc_pkg::code_t     tail_val,
  output sckc_pkg::code_t     head
);
  import sckc_pkg::*;

  code_t keys   [HELD_DEPTH];
  code_t fwd_in [HELD_DEPTH];
  code_t bwd_in [HELD_DEPTH];

  genvar i;
  generate
    for (i = 0; i < HELD_DEPTH; i++) begin : g_cell
      // Wire neighbors, with head and tail overrides on a forward shift
      always_comb begin
        if (i == 0 && ctl.head_load) begin
          fwd_in[i] = head_val;
        end else if (i == HELD_DEPTH - 1 && ctl.tail_load) begin
          fwd_in[i] = tail_val;
        end else begin
          fwd_in[i] = keys[(i + 1) % HELD_DEPTH];
        end
        bwd_in[i] = keys[(i + HELD_DEPTH - 1) % HELD_DEPTH];
      end

      sckc_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .fwd_in (fwd_in[i]),
        .bwd_in (bwd_in[i]),
        .key    (keys[i])
      );
    end
  endgenerate

  assign head = keys[0];

endmodule
